// ===== src/gmrb_pkg.sv =====
`default_nettype none

package gmrb_pkg;

  localparam int DATA_W  = 32;
  localparam int SLICE_W = 3;
  localparam int WORD_W  = 4;

  localparam int NUM_SLICES_DEFAULT = 8;

  // bus access direction
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // word offsets within a slice window (byte offset = 4 * word)
  localparam logic [WORD_W-1:0] WORD_PINS  = 4'd0;
  localparam logic [WORD_W-1:0] WORD_MODE0 = 4'd4;
  localparam logic [WORD_W-1:0] WORD_SET0  = 4'd5;
  localparam logic [WORD_W-1:0] WORD_CLR0  = 4'd6;
  localparam logic [WORD_W-1:0] WORD_MODE1 = 4'd8;
  localparam logic [WORD_W-1:0] WORD_SET1  = 4'd9;
  localparam logic [WORD_W-1:0] WORD_CLR1  = 4'd10;

  typedef logic [DATA_W-1:0] word_t;

endpackage

`default_nettype wire

// ===== src/gpio_mode_register_bank.sv =====
// GPIO mode register bank: NUM_SLICES slices of 32 pins, two mode words each.
// Input channel (in_valid/in_ready) carries one bus transaction per item:
// operation, slice, reg_word, write_data and the slice's sampled pin_levels.
// Output channel (out_valid/out_ready) returns one result per transaction:
// read_data, the slice's drive_enable/drive_level/function_select after the
// access, conflict flags and access_error.
// out_valid rises when the accepted transaction moves on from the input
// register into the result register. One input register, then the mode
// word update and decode, then the result register.
// Throughput is one transaction per cycle while out_ready stays high; the
// mode word read-modify-write completes within that one stage, so back to
// back accesses to the same slice see each other's updates.
// When the receiver stalls, the result register holds its value and the
// input register fills; in_ready then drops until the result is taken.
// Reset (rst, synchronous) clears all mode words, so every pin is an input,
// and empties both pipeline registers.
`default_nettype none

module gpio_mode_register_bank #(
  parameter int NUM_SLICES = gmrb_pkg::NUM_SLICES_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         operation,
  input  wire logic [gmrb_pkg::SLICE_W-1:0] slice,
  input  wire logic [gmrb_pkg::WORD_W-1:0]  reg_word,
  input  wire logic [gmrb_pkg::DATA_W-1:0]  write_data,
  input  wire logic [gmrb_pkg::DATA_W-1:0]  pin_levels,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [gmrb_pkg::DATA_W-1:0]       read_data,
  output logic [gmrb_pkg::DATA_W-1:0]       drive_enable,
  output logic [gmrb_pkg::DATA_W-1:0]       drive_level,
  output logic [gmrb_pkg::DATA_W-1:0]       function_select,
  output logic [gmrb_pkg::DATA_W-1:0]       conflict,
  output logic                              access_error
);

  localparam int IDX_W = (NUM_SLICES > 1) ? $clog2(NUM_SLICES) : 1;
  localparam int EXT_W = 5;  // holds any NUM_SLICES up to 31

  gmrb_pkg::word_t mode_low_bits  [NUM_SLICES];
  gmrb_pkg::word_t mode_high_bits [NUM_SLICES];

  // input register
  logic                         s1_valid;
  logic                         s1_op;
  logic [gmrb_pkg::SLICE_W-1:0] s1_slice;
  logic [gmrb_pkg::WORD_W-1:0]  s1_word;
  gmrb_pkg::word_t              s1_data;
  gmrb_pkg::word_t              s1_pins;

  logic             s1_advance;
  logic [EXT_W-1:0] slice_ext;
  logic [IDX_W-1:0] idx;
  logic             in_range;
  logic             is_write;
  gmrb_pkg::word_t  m0_cur, m1_cur;
  gmrb_pkg::word_t  m0_next, m1_next;
  gmrb_pkg::word_t  rdata_next;
  logic             err_next;

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  assign slice_ext = EXT_W'(s1_slice);
  assign in_range  = slice_ext < EXT_W'(NUM_SLICES);
  assign idx       = slice_ext[IDX_W-1:0];
  assign is_write  = (s1_op == gmrb_pkg::OP_WRITE);
  assign m0_cur    = mode_low_bits[idx];
  assign m1_cur    = mode_high_bits[idx];

  always_comb begin
    m0_next    = m0_cur;
    m1_next    = m1_cur;
    rdata_next = '0;
    err_next   = 1'b0;
    case (s1_word)
      gmrb_pkg::WORD_PINS: begin
        if (!is_write) rdata_next = s1_pins;
      end
      gmrb_pkg::WORD_MODE0: begin
        if (is_write) m0_next = s1_data;
        else          rdata_next = m0_cur;
      end
      gmrb_pkg::WORD_SET0: begin
        if (is_write) m0_next = m0_cur | s1_data;
      end
      gmrb_pkg::WORD_CLR0: begin
        if (is_write) m0_next = m0_cur & ~s1_data;
      end
      gmrb_pkg::WORD_MODE1: begin
        if (is_write) m1_next = s1_data;
        else          rdata_next = m1_cur;
      end
      gmrb_pkg::WORD_SET1: begin
        if (is_write) m1_next = m1_cur | s1_data;
      end
      gmrb_pkg::WORD_CLR1: begin
        if (is_write) m1_next = m1_cur & ~s1_data;
      end
      default: begin
        err_next = 1'b1;
      end
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op    <= operation;
      s1_slice <= slice;
      s1_word  <= reg_word;
      s1_data  <= write_data;
      s1_pins  <= pin_levels;
    end
  end

  // mode words
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLICES; i++) begin
        mode_low_bits[i]  <= '0;
        mode_high_bits[i] <= '0;
      end
    end else if (s1_advance && in_range) begin
      mode_low_bits[idx]  <= m0_next;
      mode_high_bits[idx] <= m1_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      if (in_range) begin
        read_data       <= rdata_next;
        drive_enable    <= m1_next;
        drive_level     <= m0_next;
        function_select <= ~m1_next & m0_next;
        conflict        <= m1_next & (s1_pins ^ m0_next);
        access_error    <= err_next;
      end else begin
        // slice beyond the bank: nothing touched, data outputs zero, access_error set
        read_data       <= '0;
        drive_enable    <= '0;
        drive_level     <= '0;
        function_select <= '0;
        conflict        <= '0;
        access_error    <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/gmrb_checker.sv =====
`default_nettype none

module gmrb_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [gmrb_pkg::DATA_W-1:0] read_data,
  input wire logic [gmrb_pkg::DATA_W-1:0] drive_enable,
  input wire logic [gmrb_pkg::DATA_W-1:0] function_select,
  input wire logic [gmrb_pkg::DATA_W-1:0] conflict,
  input wire logic                        access_error
);

  // no stale result survives reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high right after reset");

  // a stalled result stays put
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data)
      && $stable(drive_enable) && $stable(access_error))
    else $error("stalled result changed");

  // input side only backs up behind a stalled result
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without output stall");

  // a function pin is never a driven output, conflicts only on outputs
  a_pin_modes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (function_select & drive_enable) == '0
      && (conflict & ~drive_enable) == '0)
    else $error("inconsistent pin mode outputs");

  // failed accesses never return data
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && access_error |-> read_data == '0)
    else $error("read data on access error");

endmodule

bind gpio_mode_register_bank gmrb_checker u_gmrb_checker (
  .clk             (clk),
  .rst             (rst),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .read_data       (read_data),
  .drive_enable    (drive_enable),
  .function_select (function_select),
  .conflict        (conflict),
  .access_error    (access_error)
);

`default_nettype wire
